[hw/rtl/lpcs_pkg.sv]
// ----------------------------------------------------------------------------
// lpcs_pkg
// Types and codes shared by the landing plan command sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcs_pkg;

  localparam int PLAN_ID_W = 24;
  localparam int CRC_W     = 16;
  localparam int GEN_W     = 8;
  localparam int MODE_W    = 32;
  localparam int ATT_W     = 4;

  // Event codes carried in the input tuser.
  localparam logic [2:0] FUNC_QUERY   = 3'd0;
  localparam logic [2:0] FUNC_EXECUTE = 3'd1;
  localparam logic [2:0] FUNC_CANCEL  = 3'd2;
  localparam logic [2:0] FUNC_ACK     = 3'd3;
  localparam logic [2:0] FUNC_MODE    = 3'd4;
  localparam logic [2:0] FUNC_RETRY   = 3'd5;
  localparam logic [2:0] FUNC_VEHICLE = 3'd6;

  // Operations.
  localparam logic [2:0] OP_IDLE    = 3'd0;
  localparam logic [2:0] OP_QUERY   = 3'd1;
  localparam logic [2:0] OP_LOITER  = 3'd2;
  localparam logic [2:0] OP_LANDING = 3'd3;
  localparam logic [2:0] OP_COMMIT  = 3'd4;
  localparam logic [2:0] OP_CANCEL  = 3'd5;

  // Failure kinds of an acknowledgement.
  localparam logic [1:0] FK_RESULT      = 2'd0;
  localparam logic [1:0] FK_NO_RESPONSE = 2'd1;
  localparam logic [1:0] FK_DUPLICATE   = 2'd2;

  localparam logic [7:0] ACK_ACCEPTED = 8'd0;

  // Status codes.
  localparam logic [3:0] ST_NONE      = 4'd0;
  localparam logic [3:0] ST_NOVEH     = 4'd1;
  localparam logic [3:0] ST_INPROG    = 4'd2;
  localparam logic [3:0] ST_NOTREADY  = 4'd3;
  localparam logic [3:0] ST_NOTMODE   = 4'd4;
  localparam logic [3:0] ST_LEFTMODE  = 4'd5;
  localparam logic [3:0] ST_FAILED    = 4'd6;
  localparam logic [3:0] ST_SUPPORTED = 4'd7;
  localparam logic [3:0] ST_COMMITTED = 4'd8;
  localparam logic [3:0] ST_CANCELLED = 4'd9;
  localparam logic [3:0] ST_RETRYING  = 4'd10;
  localparam logic [3:0] ST_SENDING   = 4'd11;

  localparam logic [ATT_W-1:0] ATTEMPT_MAX = 4'd15;

  // Configuration register indexes.
  localparam logic REG_MAX_ATTEMPTS = 1'b0;
  localparam logic REG_LANDING_MODE = 1'b1;

  typedef struct packed {
    logic [ATT_W-1:0]  max_attempts;
    logic [MODE_W-1:0] landing_mode_number;
  } cfg_t;

  typedef struct packed {
    logic [2:0]           func;
    logic                 draft_valid;
    logic                 link_up;
    logic [PLAN_ID_W-1:0] new_plan_id;
    logic [CRC_W-1:0]     new_plan_crc;
    logic [2:0]           tag_operation;
    logic [GEN_W-1:0]     tag_generation;
    logic [1:0]           failure_kind;
    logic [7:0]           ack_result;
    logic [MODE_W-1:0]    custom_mode;
    logic                 vehicle_present;
  } item_t;

  typedef struct packed {
    logic                 send_valid;
    logic [2:0]           send_command;
    logic [PLAN_ID_W-1:0] send_plan_id;
    logic [CRC_W-1:0]     send_aux;
    logic [GEN_W-1:0]     send_generation;
    logic                 retry_arm;
    logic                 busy_flag;
    logic                 capability_ok;
    logic                 plan_committed;
    logic                 commit_uncertain;
    logic                 mode_active;
    logic [3:0]           status;
  } result_t;

  typedef struct packed {
    logic [2:0]           op;
    logic [ATT_W-1:0]     attempts;
    logic [GEN_W-1:0]     gen;
    logic                 busy;
    logic                 capability;
    logic                 committed;
    logic                 uncertain;
    logic                 mode;
    logic                 vehicle;
    logic [PLAN_ID_W-1:0] plan_id;
    logic [CRC_W-1:0]     plan_crc;
    logic                 cancel_action;
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/lpcs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lpcs_cfg_regs
// APB-style register file for the retry limit and the landing mode number.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcs_cfg_regs
  import lpcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_attempts        <= 4'd3;
      cfg.landing_mode_number <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MAX_ATTEMPTS: cfg.max_attempts        <= pwdata[ATT_W-1:0];
        REG_LANDING_MODE: cfg.landing_mode_number <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_ATTEMPTS: prdata = {{(32-ATT_W){1'b0}}, cfg.max_attempts};
      REG_LANDING_MODE: prdata = cfg.landing_mode_number;
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/lpcs_step.sv]
// ----------------------------------------------------------------------------
// lpcs_step
// Next-state and result logic for one event of the command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcs_step
  import lpcs_pkg::*;
(
  input  wire state_t  st,
  input  wire cfg_t    cfg,
  input  wire item_t   item,
  output state_t       st_next,
  output result_t      res
);

  state_t      s;
  result_t     r;
  logic        do_send;
  logic        do_mode;
  logic        do_retry;
  logic [1:0]  retry_fk;
  logic        veh_override;
  logic        tag_match;
  logic        may_reach;
  logic        active;
  logic        transport;

  always_comb begin
    s            = st;
    r            = '0;
    r.status     = ST_NONE;
    do_send      = 1'b0;
    do_mode      = 1'b0;
    do_retry     = 1'b0;
    retry_fk     = FK_RESULT;
    veh_override = 1'b0;
    may_reach    = 1'b0;
    active       = 1'b0;
    transport    = 1'b0;
    tag_match    = st.busy && (item.tag_generation == st.gen) &&
                   (item.tag_operation == st.op);

    unique case (item.func)
      FUNC_QUERY: begin
        if (s.busy) begin
          if (s.op != OP_QUERY) r.status = ST_INPROG;
        end else if (!s.vehicle) begin
          s.op = OP_IDLE; s.attempts = '0; s.busy = 1'b0; r.status = ST_NOVEH;
        end else begin
          s.op = OP_QUERY; s.attempts = '0; s.gen = s.gen + 1'b1; s.busy = 1'b1;
          do_send = 1'b1;
        end
      end
      FUNC_EXECUTE: begin
        if (s.busy) begin
          r.status = ST_INPROG;
        end else begin
          // Every rejection finishes the (idle) operation with an error code.
          s.op = OP_IDLE; s.attempts = '0; s.busy = 1'b0;
          if (!s.vehicle) r.status = ST_NOVEH;
          else if (!s.capability) r.status = ST_NOTREADY;
          else if (!s.mode) r.status = ST_NOTMODE;
          else if (s.committed || s.uncertain || !item.draft_valid) r.status = ST_NOTREADY;
          else if (item.new_plan_id == '0 || item.new_plan_id == s.plan_id)
            r.status = ST_NOTREADY;
          else begin
            s.uncertain = 1'b0;
            s.plan_id   = item.new_plan_id;
            s.plan_crc  = item.new_plan_crc;
            s.op = OP_LOITER; s.gen = s.gen + 1'b1; s.busy = 1'b1;
            do_send = 1'b1;
          end
        end
      end
      FUNC_CANCEL: begin
        if (!s.vehicle) begin
          s.op = OP_IDLE; s.attempts = '0; s.busy = 1'b0; r.status = ST_NOVEH;
        end else begin
          may_reach = s.committed || s.uncertain || (s.op == OP_COMMIT);
          s.gen = s.gen + 1'b1; s.op = OP_IDLE; s.attempts = '0; s.busy = 1'b0;
          if (!s.mode) begin
            s.committed = 1'b0; s.uncertain = 1'b0;
            s.plan_id = '0; s.plan_crc = '0;
            r.status = ST_NOTMODE;
          end else begin
            s.cancel_action = may_reach;
            s.op = OP_CANCEL; s.gen = s.gen + 1'b1; s.busy = 1'b1;
            do_send = 1'b1;
          end
        end
      end
      FUNC_ACK: begin
        if (tag_match) begin
          if (!(item.failure_kind == FK_RESULT && item.ack_result == ACK_ACCEPTED)) begin
            do_retry = 1'b1;
            retry_fk = item.failure_kind;
          end else begin
            unique case (s.op)
              OP_QUERY: begin
                s.capability = 1'b1;
                s.op = OP_IDLE; s.attempts = '0; s.busy = 1'b0; r.status = ST_SUPPORTED;
              end
              OP_LOITER: begin
                s.op = OP_LANDING; s.attempts = '0; do_send = 1'b1;
              end
              OP_LANDING: begin
                s.op = OP_COMMIT; s.attempts = '0; do_send = 1'b1;
              end
              OP_COMMIT: begin
                s.uncertain = 1'b0; s.committed = 1'b1;
                s.op = OP_IDLE; s.attempts = '0; s.busy = 1'b0; r.status = ST_COMMITTED;
              end
              OP_CANCEL: begin
                s.uncertain = 1'b0; s.committed = 1'b0;
                s.plan_id = '0; s.plan_crc = '0;
                s.op = OP_IDLE; s.attempts = '0; s.busy = 1'b0; r.status = ST_CANCELLED;
              end
              default: ;
            endcase
          end
        end
      end
      FUNC_MODE: begin
        do_mode = 1'b1;
      end
      FUNC_RETRY: begin
        do_send = tag_match;
      end
      FUNC_VEHICLE: begin
        if (item.vehicle_present || s.vehicle) begin
          s.gen = s.gen + 1'b1; s.op = OP_IDLE; s.attempts = '0; s.busy = 1'b0;
          s.vehicle    = item.vehicle_present;
          s.capability = 1'b0; s.committed = 1'b0; s.uncertain = 1'b0;
          s.plan_id    = '0;   s.plan_crc  = '0;
          do_mode      = 1'b1;
          veh_override = 1'b1;
        end
      end
      default: ;
    endcase

    // Mode tracking, shared by mode reports and vehicle changes.
    if (do_mode) begin
      active = s.vehicle && (item.custom_mode == cfg.landing_mode_number);
      if (active != s.mode) begin
        s.mode = active; s.committed = 1'b0; s.uncertain = 1'b0;
        if (!active) begin
          r.status = ST_NOTMODE;
          if (s.busy && s.op != OP_QUERY) begin
            s.gen = s.gen + 1'b1; s.op = OP_IDLE; s.attempts = '0; s.busy = 1'b0;
            r.status = ST_LEFTMODE;
          end
        end
      end
    end

    // Send the command of the current operation.
    if (do_send) begin
      if (!s.vehicle) begin
        s.op = OP_IDLE; s.attempts = '0; s.busy = 1'b0; r.status = ST_NOVEH;
      end else if (s.op != OP_QUERY && !s.mode) begin
        s.op = OP_IDLE; s.attempts = '0; s.busy = 1'b0; r.status = ST_NOTMODE;
      end else begin
        if (s.attempts < ATTEMPT_MAX) s.attempts = s.attempts + 1'b1;
        if (s.op != OP_IDLE && s.op <= OP_CANCEL) begin
          if (!item.link_up) begin
            do_retry = 1'b1;
            retry_fk = FK_NO_RESPONSE;
          end else begin
            r.send_valid      = 1'b1;
            r.send_command    = s.op - 1'b1;
            r.send_generation = s.gen;
            r.send_plan_id    = (s.op == OP_QUERY) ? '0 : s.plan_id;
            if (s.op == OP_COMMIT) r.send_aux = s.plan_crc;
            else if (s.op == OP_CANCEL) r.send_aux = {{(CRC_W-1){1'b0}}, s.cancel_action};
            r.status = ST_SENDING;
          end
        end
      end
    end

    // Transport failures are retried until the attempt limit is reached.
    if (do_retry) begin
      transport = (retry_fk == FK_NO_RESPONSE) || (retry_fk == FK_DUPLICATE);
      if (s.op == OP_COMMIT && transport) s.uncertain = 1'b1;
      if (transport && s.attempts < cfg.max_attempts) begin
        r.retry_arm       = 1'b1;
        r.send_command    = s.op - 1'b1;
        r.send_generation = s.gen;
        r.status          = ST_RETRYING;
      end else begin
        if (s.op == OP_QUERY) s.capability = 1'b0;
        s.op = OP_IDLE; s.attempts = '0; s.busy = 1'b0; r.status = ST_FAILED;
      end
    end

    if (veh_override) r.status = item.vehicle_present ? ST_NONE : ST_NOVEH;

    r.busy_flag        = s.busy;
    r.capability_ok    = s.capability;
    r.plan_committed   = s.committed;
    r.commit_uncertain = s.uncertain;
    r.mode_active      = s.mode;

    st_next = s;
    res     = r;
  end

endmodule

`default_nettype wire

[hw/rtl/landing_plan_command_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// landing_plan_command_sequencer_unit
// Acknowledged three-command landing plan sequencer with retry and cancel.
// ----------------------------------------------------------------------------
// Each event item is captured in an input register, evaluated against the
// sequencer state in combinational logic, and its single result item is held
// in an output register while the state updates on the same edge. The block
// takes one item per clock while the output is not stalled; a result waits in
// the output register until it is taken. While a result waits, the input register
// can still take one more item, and then the input stalls until the result is
// taken. Configuration is read and written through the APB port at byte
// addresses 0 (retry limit) and 4 (landing mode number).
`default_nettype none

module landing_plan_command_sequencer_unit
  import lpcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Input events.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata, from bit 0: draft_valid, link_up, new_plan_id[23:0], new_plan_crc[15:0],
  // tag_operation[2:0], tag_generation[7:0], failure_kind[1:0], ack_result[7:0],
  // custom_mode[31:0], vehicle_present.
  input  wire logic [95:0] s_tdata,
  // tuser: func[2:0].
  input  wire logic [2:0]  s_tuser,
  // Results.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata, from bit 0: send_valid, send_plan_id[23:0], send_aux[15:0],
  // send_generation[7:0], retry_arm, busy_flag, capability_ok, plan_committed,
  // commit_uncertain, mode_active, status[3:0], zero padding.
  output logic [63:0]      m_tdata,
  // tuser: send_command[2:0].
  output logic [2:0]       m_tuser,
  // Configuration.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  state_t  st;
  state_t  st_next;
  result_t res;
  result_t out_res;
  logic    advance;

  lpcs_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpcs_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (in_item),
    .st_next (st_next),
    .res     (res)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.func            <= s_tuser;
      in_item.draft_valid     <= s_tdata[0];
      in_item.link_up         <= s_tdata[1];
      in_item.new_plan_id     <= s_tdata[25:2];
      in_item.new_plan_crc    <= s_tdata[41:26];
      in_item.tag_operation   <= s_tdata[44:42];
      in_item.tag_generation  <= s_tdata[52:45];
      in_item.failure_kind    <= s_tdata[54:53];
      in_item.ack_result      <= s_tdata[62:55];
      in_item.custom_mode     <= s_tdata[94:63];
      in_item.vehicle_present <= s_tdata[95];
    end
    if (advance) out_res <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      st       <= '0;
    end else begin
      if (s_tvalid && s_tready) in_valid <= 1'b1;
      else if (advance)         in_valid <= 1'b0;
      if (advance)              m_tvalid <= 1'b1;
      else if (m_tready)        m_tvalid <= 1'b0;
      if (advance)              st <= st_next;
    end
  end

  assign m_tuser = out_res.send_command;
  assign m_tdata = {5'b0,
                    out_res.status,
                    out_res.mode_active,
                    out_res.commit_uncertain,
                    out_res.plan_committed,
                    out_res.capability_ok,
                    out_res.busy_flag,
                    out_res.retry_arm,
                    out_res.send_generation,
                    out_res.send_aux,
                    out_res.send_plan_id,
                    out_res.send_valid};

  // An operation is only left in flight while the sequencer is busy.
  a_idle_when_not_busy: assert property (@(posedge clk) disable iff (rst)
    !st.busy |-> st.op == OP_IDLE)
    else $error("sequencer idle but operation not cleared");

  a_send_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.send_valid |-> out_res.status == ST_SENDING)
    else $error("command sent without sending status");

  a_send_or_arm: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_res.send_valid && out_res.retry_arm))
    else $error("send and retry arm in the same result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

[tb/tb_landing_plan_command_sequencer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_landing_plan_command_sequencer_unit
// Self-checking testbench for the landing plan command sequencer.
// ----------------------------------------------------------------------------
// Event items are driven on the input stream and run through a predictor of
// the sequencer that keeps its own copy of state and configuration. Every
// result item is compared field by field with the oldest prediction. The run
// covers directed corner cases, retry limits, long randomized traffic that
// mostly follows the query, execute, acknowledge and cancel flows, and a
// stretch of output back-pressure.

module tb_landing_plan_command_sequencer_unit;
  import lpcs_pkg::*;

  localparam int          RESULT_LATENCY = 2;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic [2:0]  FUNC_UNUSED    = 3'd7;
  localparam logic [1:0]  FK_OTHER       = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  landing_plan_command_sequencer_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Predictor state and configuration.
  state_t  seq;
  cfg_t    cfg;
  result_t pred;
  logic    link_now;

  result_t expected_results[$];
  int      fail_count = 0;
  int      send_gap_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_off_left = 0;
  int      idle_cycles = 0;

  // ---------------------------------------------------------------- predictor
  function automatic void close_op(input logic [3:0] st);
    seq.op = OP_IDLE;
    seq.attempts = '0;
    seq.busy = 1'b0;
    pred.status = st;
  endfunction

  // Dropping an operation bumps the generation so its late acks go stale.
  function automatic void drop_op();
    seq.gen = seq.gen + 1'b1;
    seq.op = OP_IDLE;
    seq.attempts = '0;
    seq.busy = 1'b0;
  endfunction

  function automatic void retry_or_give_up(input logic [1:0] kind);
    logic transport;
    transport = (kind == FK_NO_RESPONSE) || (kind == FK_DUPLICATE);
    if (seq.op == OP_COMMIT && transport) seq.uncertain = 1'b1;
    if (transport && seq.attempts < cfg.max_attempts) begin
      pred.retry_arm = 1'b1;
      pred.send_command = seq.op - 3'd1;
      pred.send_generation = seq.gen;
      pred.status = ST_RETRYING;
    end else begin
      if (seq.op == OP_QUERY) seq.capability = 1'b0;
      close_op(ST_FAILED);
    end
  endfunction

  function automatic void issue_command();
    if (!seq.vehicle) begin
      close_op(ST_NOVEH);
    end else if (seq.op != OP_QUERY && !seq.mode) begin
      close_op(ST_NOTMODE);
    end else begin
      if (seq.attempts != ATTEMPT_MAX) seq.attempts = seq.attempts + 1'b1;
      if (seq.op != OP_IDLE && seq.op <= OP_CANCEL) begin
        if (!link_now) begin
          retry_or_give_up(FK_NO_RESPONSE);
        end else begin
          pred.send_valid = 1'b1;
          pred.send_command = seq.op - 3'd1;
          pred.send_generation = seq.gen;
          pred.send_plan_id = (seq.op == OP_QUERY) ? '0 : seq.plan_id;
          if (seq.op == OP_COMMIT) pred.send_aux = seq.plan_crc;
          else if (seq.op == OP_CANCEL) pred.send_aux = {15'd0, seq.cancel_action};
          pred.status = ST_SENDING;
        end
      end
    end
  endfunction

  function automatic void begin_op(input logic [2:0] op);
    seq.op = op;
    seq.attempts = '0;
    seq.gen = seq.gen + 1'b1;
    seq.busy = 1'b1;
    issue_command();
  endfunction

  function automatic void track_mode(input logic [31:0] flight_mode);
    logic active;
    active = seq.vehicle && (flight_mode == cfg.landing_mode_number);
    if (active != seq.mode) begin
      seq.mode = active;
      seq.committed = 1'b0;
      seq.uncertain = 1'b0;
      if (!active) begin
        pred.status = ST_NOTMODE;
        if (seq.busy && seq.op != OP_QUERY) begin
          drop_op();
          pred.status = ST_LEFTMODE;
        end
      end
    end
  endfunction

  function automatic result_t predict_event(input item_t ev);
    logic may_be_on_vehicle;
    pred = '0;
    link_now = ev.link_up;
    case (ev.func)
      FUNC_QUERY: begin
        if (seq.busy) begin
          if (seq.op != OP_QUERY) pred.status = ST_INPROG;
        end else if (!seq.vehicle) begin
          close_op(ST_NOVEH);
        end else begin
          begin_op(OP_QUERY);
        end
      end
      FUNC_EXECUTE: begin
        if (seq.busy) pred.status = ST_INPROG;
        else if (!seq.vehicle) close_op(ST_NOVEH);
        else if (!seq.capability) close_op(ST_NOTREADY);
        else if (!seq.mode) close_op(ST_NOTMODE);
        else if (seq.committed || seq.uncertain || !ev.draft_valid) close_op(ST_NOTREADY);
        else if (ev.new_plan_id == '0 || ev.new_plan_id == seq.plan_id) close_op(ST_NOTREADY);
        else begin
          seq.uncertain = 1'b0;
          seq.plan_id = ev.new_plan_id;
          seq.plan_crc = ev.new_plan_crc;
          begin_op(OP_LOITER);
        end
      end
      FUNC_CANCEL: begin
        if (!seq.vehicle) begin
          close_op(ST_NOVEH);
        end else begin
          may_be_on_vehicle = seq.committed || seq.uncertain || seq.op == OP_COMMIT;
          drop_op();
          if (!seq.mode) begin
            seq.committed = 1'b0;
            seq.uncertain = 1'b0;
            seq.plan_id = '0;
            seq.plan_crc = '0;
            pred.status = ST_NOTMODE;
          end else begin
            seq.cancel_action = may_be_on_vehicle;
            begin_op(OP_CANCEL);
          end
        end
      end
      FUNC_ACK: begin
        if (seq.busy && ev.tag_generation == seq.gen && ev.tag_operation == seq.op) begin
          if (!(ev.failure_kind == FK_RESULT && ev.ack_result == ACK_ACCEPTED)) begin
            retry_or_give_up(ev.failure_kind);
          end else begin
            case (seq.op)
              OP_QUERY: begin
                seq.capability = 1'b1;
                close_op(ST_SUPPORTED);
              end
              OP_LOITER, OP_LANDING: begin
                seq.op = seq.op + 3'd1;
                seq.attempts = '0;
                issue_command();
              end
              OP_COMMIT: begin
                seq.uncertain = 1'b0;
                seq.committed = 1'b1;
                close_op(ST_COMMITTED);
              end
              OP_CANCEL: begin
                seq.uncertain = 1'b0;
                seq.committed = 1'b0;
                seq.plan_id = '0;
                seq.plan_crc = '0;
                close_op(ST_CANCELLED);
              end
              default: ;
            endcase
          end
        end
      end
      FUNC_MODE: track_mode(ev.custom_mode);
      FUNC_RETRY: begin
        if (seq.busy && ev.tag_generation == seq.gen && ev.tag_operation == seq.op)
          issue_command();
      end
      FUNC_VEHICLE: begin
        if (ev.vehicle_present || seq.vehicle) begin
          drop_op();
          seq.vehicle = ev.vehicle_present;
          seq.capability = 1'b0;
          seq.committed = 1'b0;
          seq.uncertain = 1'b0;
          seq.plan_id = '0;
          seq.plan_crc = '0;
          track_mode(ev.custom_mode);
          pred.status = ev.vehicle_present ? ST_NONE : ST_NOVEH;
        end
      end
      default: ;
    endcase
    pred.busy_flag = seq.busy;
    pred.capability_ok = seq.capability;
    pred.plan_committed = seq.committed;
    pred.commit_uncertain = seq.uncertain;
    pred.mode_active = seq.mode;
    return pred;
  endfunction

  // ---------------------------------------------------------------- stimulus
  // A well-formed event for the current sequencer state: tag of the running
  // operation, accepted ack, link up, vehicle in the landing mode.
  function automatic item_t event_item(input logic [2:0] func);
    item_t ev;
    ev.func = func;
    ev.draft_valid = 1'b1;
    ev.link_up = 1'b1;
    do ev.new_plan_id = 24'($urandom_range(1, 24'hFFFFFF));
    while (ev.new_plan_id == seq.plan_id);
    ev.new_plan_crc = 16'($urandom);
    ev.tag_operation = seq.op;
    ev.tag_generation = seq.gen;
    ev.failure_kind = FK_RESULT;
    ev.ack_result = ACK_ACCEPTED;
    ev.custom_mode = cfg.landing_mode_number;
    ev.vehicle_present = 1'b1;
    return ev;
  endfunction

  // Mostly steers the sequencer through its flows; a fifth is pure noise.
  function automatic item_t next_event();
    item_t        ev;
    logic [127:0] raw;
    int unsigned  roll;
    int unsigned  sub;
    roll = $urandom_range(99);
    sub = $urandom_range(99);
    if (roll < 20) begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      ev = raw[$bits(item_t)-1:0];
      ev.func = 3'($urandom_range(0, 7));
      if (sub < 40) begin
        ev.tag_operation = seq.op;
        ev.tag_generation = seq.gen;
      end
      return ev;
    end
    roll = $urandom_range(99);
    if (!seq.vehicle) begin
      ev = event_item(FUNC_VEHICLE);
      if (roll < 15) ev.custom_mode = $urandom;
      if (roll >= 90) ev.func = 3'($urandom_range(0, 2));
    end else if (!seq.mode) begin
      ev = event_item(FUNC_MODE);
      if (roll < 10) ev.custom_mode = $urandom;
      else if (roll < 20) ev.func = FUNC_QUERY;
      else if (roll < 25) ev.func = FUNC_CANCEL;
    end else if (seq.busy) begin
      ev = event_item(FUNC_ACK);
      if (roll < 62) begin
        if (sub < 8) ev.failure_kind = FK_NO_RESPONSE;
        else if (sub < 14) ev.failure_kind = FK_DUPLICATE;
        else if (sub < 17) ev.failure_kind = FK_OTHER;
        else if (sub < 21) ev.ack_result = 8'($urandom_range(1, 255));
        else if (sub >= 94) ev.tag_generation = ev.tag_generation - 8'd1;
      end else if (roll < 80) begin
        ev.func = FUNC_RETRY;
        ev.link_up = (sub < 80);
      end else if (roll < 85) begin
        ev.func = FUNC_CANCEL;
        ev.link_up = (sub < 85);
      end else if (roll < 90) begin
        ev.func = (sub < 50) ? FUNC_QUERY : FUNC_EXECUTE;
      end else if (roll < 95) begin
        ev.func = FUNC_MODE;
        ev.custom_mode = $urandom;
      end else begin
        ev.func = FUNC_VEHICLE;
        ev.vehicle_present = 1'($urandom);
        if (sub < 50) ev.custom_mode = $urandom;
      end
    end else if (!seq.capability) begin
      ev = event_item(FUNC_QUERY);
      ev.link_up = (sub < 85);
      if (roll >= 92) ev.func = FUNC_EXECUTE;
    end else if (seq.committed || seq.uncertain) begin
      ev = event_item(FUNC_CANCEL);
      ev.link_up = (sub < 90);
      if (roll >= 95) ev.func = FUNC_VEHICLE;
      else if (roll >= 85) ev.func = FUNC_QUERY;
      else if (roll >= 75) begin
        ev.func = FUNC_MODE;
        ev.custom_mode = $urandom;
      end else if (roll >= 55) ev.func = FUNC_EXECUTE;
    end else begin
      ev = event_item(FUNC_EXECUTE);
      ev.link_up = (sub < 88);
      ev.draft_valid = ($urandom_range(99) < 92);
      if (sub >= 96) ev.new_plan_id = seq.plan_id;
      else if (sub >= 94) ev.new_plan_id = '0;
      if (roll >= 95) begin
        ev.func = FUNC_MODE;
        ev.custom_mode = $urandom;
      end else if (roll >= 88) ev.func = FUNC_QUERY;
      else if (roll >= 80) ev.func = FUNC_CANCEL;
    end
    return ev;
  endfunction

  task automatic send_event(input item_t ev);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ev.vehicle_present, ev.custom_mode, ev.ack_result, ev.failure_kind,
                ev.tag_generation, ev.tag_operation, ev.new_plan_crc, ev.new_plan_id,
                ev.link_up, ev.draft_valid};
    s_tuser <= ev.func;
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_event(ev));
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (expected_results.size() == 0);
  endtask

  task automatic write_reg(input logic reg_index, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_index, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_index == REG_MAX_ATTEMPTS) cfg.max_attempts = value[ATT_W-1:0];
    else cfg.landing_mode_number = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [3:0] attempts, input logic [31:0] landing_mode);
    wait_results_done();
    write_reg(REG_MAX_ATTEMPTS, {28'd0, attempts});
    write_reg(REG_LANDING_MODE, landing_mode);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    item_t ev;
    send_event(event_item(FUNC_UNUSED));
    send_event(event_item(FUNC_QUERY));
    send_event(event_item(FUNC_EXECUTE));
    send_event(event_item(FUNC_CANCEL));
    ev = event_item(FUNC_VEHICLE);
    ev.vehicle_present = 1'b0;
    send_event(ev);
    send_event(event_item(FUNC_VEHICLE));
    // Attaching over an attached vehicle starts over, here outside the mode.
    ev = event_item(FUNC_VEHICLE);
    ev.custom_mode = 32'hFFFF_FFFF;
    send_event(ev);
    ev.func = FUNC_MODE;
    send_event(ev);
    send_event(event_item(FUNC_EXECUTE));
    ev = event_item(FUNC_QUERY);
    ev.link_up = 1'b0;
    send_event(ev);
    send_event(event_item(FUNC_QUERY));
    send_event(event_item(FUNC_EXECUTE));
    ev = event_item(FUNC_RETRY);
    ev.tag_generation = ev.tag_generation + 8'd1;
    send_event(ev);
    send_event(event_item(FUNC_RETRY));
    send_event(event_item(FUNC_ACK));
    send_event(event_item(FUNC_EXECUTE));
    send_event(event_item(FUNC_MODE));
    ev = event_item(FUNC_EXECUTE);
    ev.draft_valid = 1'b0;
    send_event(ev);
    ev = event_item(FUNC_EXECUTE);
    ev.new_plan_id = '0;
    send_event(ev);
    ev = event_item(FUNC_EXECUTE);
    ev.new_plan_id = 24'hFFFFFF;
    ev.new_plan_crc = 16'hFFFF;
    send_event(ev);
    ev = event_item(FUNC_ACK);
    ev.tag_operation = OP_LANDING;
    send_event(ev);
    send_event(event_item(FUNC_ACK));
    send_event(event_item(FUNC_ACK));
    // A lost ack during commit leaves the commit in doubt.
    ev = event_item(FUNC_ACK);
    ev.failure_kind = FK_NO_RESPONSE;
    send_event(ev);
    ev = event_item(FUNC_ACK);
    ev.ack_result = 8'hFF;
    send_event(ev);
    send_event(event_item(FUNC_CANCEL));
    send_event(event_item(FUNC_ACK));
    ev = event_item(FUNC_EXECUTE);
    ev.link_up = 1'b0;
    send_event(ev);
    ev = event_item(FUNC_MODE);
    ev.custom_mode = ev.custom_mode + 32'd1;
    send_event(ev);
    ev = event_item(FUNC_VEHICLE);
    ev.vehicle_present = 1'b0;
    send_event(ev);
  endtask

  // Drives transport failures until the operation gives up, for the
  // smallest, a single and the largest retry limit.
  task automatic test_retry_limits();
    item_t      ev;
    logic [3:0] limits[3] = '{4'd0, 4'd1, 4'd15};
    int         steps;
    foreach (limits[i]) begin
      set_config(limits[i], $urandom);
      send_event(event_item(FUNC_VEHICLE));
      ev = event_item(FUNC_QUERY);
      ev.link_up = 1'b0;
      send_event(ev);
      steps = 0;
      while (seq.busy && steps < 40) begin
        ev = event_item(FUNC_RETRY);
        ev.link_up = 1'b0;
        if ($urandom_range(99) < 30) begin
          ev.func = FUNC_ACK;
          ev.failure_kind = 2'($urandom_range(FK_NO_RESPONSE, FK_DUPLICATE));
        end
        send_event(ev);
        steps++;
      end
    end
  endtask

  task automatic test_random_traffic(input int count, input int gap_pct, input int stall_pct);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_event(next_event());
    wait_results_done();
  endtask

  // The receiver holds off long enough for the block to fill and stall its
  // input, then the sender waits for every result before going on.
  task automatic test_backpressure();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_off_left = 80;
    repeat (40) send_event(next_event());
    wait_results_done();
    repeat (20) send_event(next_event());
    wait_results_done();
  endtask

  // ---------------------------------------------------------------- checking
  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      m_tready <= 1'b0;
      hold_off_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result item with none expected: tdata %0h tuser %0h", m_tdata, m_tuser);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("send_valid", 32'(want.send_valid), 32'(m_tdata[0]));
        compare_field("send_command", 32'(want.send_command), 32'(m_tuser));
        compare_field("send_plan_id", 32'(want.send_plan_id), 32'(m_tdata[24:1]));
        compare_field("send_aux", 32'(want.send_aux), 32'(m_tdata[40:25]));
        compare_field("send_generation", 32'(want.send_generation), 32'(m_tdata[48:41]));
        compare_field("retry_arm", 32'(want.retry_arm), 32'(m_tdata[49]));
        compare_field("busy_flag", 32'(want.busy_flag), 32'(m_tdata[50]));
        compare_field("capability_ok", 32'(want.capability_ok), 32'(m_tdata[51]));
        compare_field("plan_committed", 32'(want.plan_committed), 32'(m_tdata[52]));
        compare_field("commit_uncertain", 32'(want.commit_uncertain), 32'(m_tdata[53]));
        compare_field("mode_active", 32'(want.mode_active), 32'(m_tdata[54]));
        compare_field("status", 32'(want.status), 32'(m_tdata[58:55]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    seq = '0;
    cfg.max_attempts = 4'd3;
    cfg.landing_mode_number = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_retry_limits();
    set_config(4'd15, 32'hFFFF_FFFF);
    test_random_traffic(400, 0, 0);
    set_config(4'd1, $urandom);
    test_random_traffic(400, 65, 0);
    set_config(4'd4, 32'd0);
    test_random_traffic(400, 0, 65);
    set_config(4'($urandom_range(1, 15)), $urandom);
    test_random_traffic(400, 21, 21);
    test_backpressure();

    repeat (RESULT_LATENCY + 4) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
